FILE: src/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: src/crtr_pkg.sv
package crtr_pkg;

  // Word field widths
  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned INDEX_W     = 12;
  localparam int unsigned COLUMN_W    = 4;
  localparam int unsigned STATUS_W    = 2;

  // Configuration port
  localparam int unsigned NUM_COLS_W  = 5;
  localparam int unsigned OUT_STEPS_W = 13;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_STEPS = 2'd1;

  localparam logic [NUM_COLS_W-1:0]  NUM_COLS_RST  = 5'd1;
  localparam logic [OUT_STEPS_W-1:0] OUT_STEPS_RST = 13'd2;

  // Actions
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NOP   = 2'd3;

  // Result status
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FEW_ROWS  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUT_RANGE = 2'd2;

  // Datapath widths
  localparam int unsigned PHASE_W = 16;
  localparam int unsigned DVS_W   = OUT_STEPS_W;
  localparam int unsigned MUL_A_W = 17;
  localparam int unsigned MUL_B_W = 21;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned T_W     = 17;
  localparam int unsigned C_W     = 21;
  localparam int unsigned X_W     = 40;
  localparam int unsigned X_LO_W  = 19;
  localparam int unsigned ACC_W   = 58;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: src/crtr_ram.sv
module crtr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/crtr_div.sv
module crtr_div #(
  parameter int unsigned DVD_W = 38
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [DVD_W-1:0]           dividend_i,
  input  logic [crtr_pkg::DVS_W-1:0] divisor_i,
  output logic [DVD_W-1:0]           quotient_o,
  output crtr_pkg::div_stat_t        stat_o
);

  import crtr_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W:0]   rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  // One quotient bit per cycle, restoring form
  always_comb begin
    rem_sh = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
    fits   = rem_sh >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DVD_W-2:0], fits};
      rem_d = fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

FILE: src/catmull_rom_trajectory_resampler.sv
// Clear and load words leave the block idle; a new word is taken in the next cycle.
// A query runs the shared bit-serial divider for W = 28 + clog2(MAX_ROWS)
// quotient bits: first the row count, then source position and phase,
// the latter skipped when the query ends early on status or the time column.
// Input stalls while a query runs, until its result is in the output register.
// Reset: async, active low; clears count and sequencer, sets config to defaults; store undefined.
`include "assert_macros.svh"

module catmull_rom_trajectory_resampler #(
  parameter int unsigned MAX_ROWS      = 1024,
  parameter int unsigned MAX_COLS      = 16,
  parameter int unsigned MAX_OUT_STEPS = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input words
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [crtr_pkg::ACTION_W-1:0]     action_i,
  input  logic signed [crtr_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [crtr_pkg::INDEX_W-1:0]      out_index_i,
  input  logic [crtr_pkg::COLUMN_W-1:0]     column_i,
  // result words
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [crtr_pkg::SAMPLE_W-1:0] value_o,
  output logic                              saturated_o,
  output logic [crtr_pkg::STATUS_W-1:0]     status_o,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [crtr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [crtr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import crtr_pkg::*;

  localparam int unsigned DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned LD_W    = $clog2(DEPTH + 1);
  localparam int unsigned RW      = $clog2(MAX_ROWS + 1);
  localparam int unsigned RIDX_W  = $clog2(MAX_ROWS);
  localparam int unsigned POS_W   = INDEX_W + RIDX_W;
  localparam int unsigned DVD_W   = (LD_W > POS_W + PHASE_W) ? LD_W : POS_W + PHASE_W;

  // Sequencer states
  localparam int unsigned STATE_W = 5;
  localparam logic [STATE_W-1:0] S_IDLE  = 5'd0;
  localparam logic [STATE_W-1:0] S_ROWS  = 5'd1;
  localparam logic [STATE_W-1:0] S_CHECK = 5'd2;
  localparam logic [STATE_W-1:0] S_POS   = 5'd3;
  localparam logic [STATE_W-1:0] S_DIV   = 5'd4;
  localparam logic [STATE_W-1:0] S_ADDR  = 5'd5;
  localparam logic [STATE_W-1:0] S_BASE  = 5'd6;
  localparam logic [STATE_W-1:0] S_READ  = 5'd7;
  localparam logic [STATE_W-1:0] S_COEF  = 5'd8;
  localparam logic [STATE_W-1:0] S_MC3   = 5'd9;
  localparam logic [STATE_W-1:0] S_ASUM  = 5'd10;
  localparam logic [STATE_W-1:0] S_MLO   = 5'd11;
  localparam logic [STATE_W-1:0] S_MHI   = 5'd12;
  localparam logic [STATE_W-1:0] S_SUM   = 5'd13;
  localparam logic [STATE_W-1:0] S_UPD   = 5'd14;
  localparam logic [STATE_W-1:0] S_FIN   = 5'd15;
  localparam logic [STATE_W-1:0] S_DONE  = 5'd16;

  localparam logic signed [ACC_W-1:0] RND16 = ACC_W'(32768);
  localparam logic signed [X_W:0]     RND17 = (X_W + 1)'(65536);
  localparam logic signed [X_W:0]     R_MAX = (X_W + 1)'(32767);
  localparam logic signed [X_W:0]     R_MIN = (X_W + 1)'(-32768);
  localparam logic signed [SAMPLE_W-1:0] V_MAX = SAMPLE_W'(32767);
  localparam logic signed [SAMPLE_W-1:0] V_MIN = SAMPLE_W'(-32768);

  // Control and configuration
  logic [STATE_W-1:0]     state_q, state_d;
  logic [LD_W-1:0]        loaded_q, loaded_d;
  logic [NUM_COLS_W-1:0]  num_cols_q, num_cols_d;
  logic [OUT_STEPS_W-1:0] out_steps_q, out_steps_d;
  logic [2:0]             rd_cnt_q, rd_cnt_d;
  logic                   pass_q, pass_d;
  logic                   out_valid_q, out_valid_d;

  // Query working registers
  logic [INDEX_W-1:0]     idx_q, idx_d;
  logic [COLUMN_W-1:0]    col_q, col_d;
  logic [RW-1:0]          rows_q, rows_d;
  logic [RIDX_W-1:0]      prev_q, prev_d;
  logic [PHASE_W-1:0]     phase_q, phase_d;
  logic                   has_prev_q, has_prev_d;
  logic                   has_next_q, has_next_d;
  logic                   has_after_q, has_after_d;
  logic [ADDR_W-1:0]      base_q, base_d;
  logic [ADDR_W-1:0]      rd_addr_q, rd_addr_d;
  logic signed [SAMPLE_W-1:0] p0_q, p0_d, p1_q, p1_d, p2_q, p2_d, p3_q, p3_d;
  logic signed [T_W-1:0]  t1_q, t1_d;
  logic signed [C_W-1:0]  c2_q, c2_d, c3_q, c3_d;
  logic signed [MUL_P_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0] part_q, part_d, sum_q, sum_d;
  logic signed [X_W-1:0]  x_q, x_d;
  logic signed [SAMPLE_W-1:0] res_value_q, res_value_d;
  logic                   res_sat_q, res_sat_d;
  logic [STATUS_W-1:0]    res_status_q, res_status_d;
  logic signed [SAMPLE_W-1:0] value_q, value_d;
  logic                   sat_q, sat_d;
  logic [STATUS_W-1:0]    status_q, status_d;

  // Combinational helpers
  logic [NUM_COLS_W-1:0]  ncols;
  logic [OUT_STEPS_W-1:0] steps;
  logic [ADDR_W-1:0]      ncols_a;
  logic [RIDX_W-1:0]      rows_m1;
  logic                   in_acc;
  logic                   load_ok;
  logic                   div_start;
  logic [DVD_W-1:0]       div_dvd;
  logic [DVS_W-1:0]       div_dvs;
  logic [DVD_W-1:0]       div_quo;
  div_stat_t              div_stat;
  logic [RIDX_W-1:0]      q_prev;
  logic                   q_has_next;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [T_W-1:0]  t1_w, t2_w;
  logic signed [C_W-1:0]  d21_w;
  logic signed [ACC_W-1:0] tail;
  logic signed [X_W:0]    fin_sum, fin_r;
  logic                   ram_we;
  logic [SAMPLE_W-1:0]    ram_rdata;

  // Effective register values
  always_comb begin
    if (num_cols_q == '0) begin
      ncols = NUM_COLS_W'(1);
    end else if (32'(num_cols_q) > MAX_COLS) begin
      ncols = NUM_COLS_W'(MAX_COLS);
    end else begin
      ncols = num_cols_q;
    end
    if (out_steps_q < OUT_STEPS_W'(2)) begin
      steps = OUT_STEPS_W'(2);
    end else if (32'(out_steps_q) > MAX_OUT_STEPS) begin
      steps = OUT_STEPS_W'(MAX_OUT_STEPS);
    end else begin
      steps = out_steps_q;
    end
  end

  assign ncols_a    = ADDR_W'(ncols);
  assign rows_m1    = RIDX_W'(rows_q - 1'b1);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign load_ok    = in_acc && (action_i == ACT_LOAD) && (loaded_q < LD_W'(DEPTH));
  assign ram_we     = load_ok;
  assign cfg_ready_o = 1'b1;

  // Shared divider: first the row count, then position * 2^16 / (steps - 1)
  assign div_start = (in_acc && (action_i == ACT_QUERY)) || (state_q == S_POS);
  assign div_dvd   = (state_q == S_POS) ?
                     DVD_W'({prod_q[POS_W-1:0], {PHASE_W{1'b0}}}) : DVD_W'(loaded_q);
  assign div_dvs   = (state_q == S_POS) ? DVS_W'(steps - 1'b1) : DVS_W'(ncols);

  crtr_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  crtr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (loaded_q[ADDR_W-1:0]),
    .wdata_i (sample_i),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  // Quotient splits into source row and Q0.16 phase
  assign q_prev     = div_quo[PHASE_W +: RIDX_W];
  assign q_has_next = q_prev < rows_m1;

  // Shared multiplier operand select
  always_comb begin
    mul_a = $signed({1'b0, phase_q});
    mul_b = c3_q;
    case (state_q)
      S_CHECK: begin
        mul_a = $signed(MUL_A_W'(idx_q));
        mul_b = $signed(MUL_B_W'(rows_m1));
      end
      S_ADDR: begin
        mul_a = $signed(MUL_A_W'(ncols));
        mul_b = $signed(MUL_B_W'(prev_q));
      end
      S_MLO: begin
        mul_b = $signed({2'b00, x_q[X_LO_W-1:0]});
      end
      S_MHI: begin
        mul_b = $signed(x_q[X_W-1:X_LO_W]);
      end
      default: begin
        mul_b = c3_q;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Spline coefficients from the four neighbor rows
  assign t1_w  = T_W'(p2_q) - T_W'(p0_q);
  assign t2_w  = T_W'(p3_q) - T_W'(p1_q);
  assign d21_w = C_W'(p2_q) - C_W'(p1_q);

  assign tail    = sum_q >>> PHASE_W;
  assign fin_sum = (X_W + 1)'(x_q) + RND17;
  assign fin_r   = fin_sum >>> (PHASE_W + 1);

  always_comb begin
    state_d      = state_q;
    loaded_d     = loaded_q;
    num_cols_d   = num_cols_q;
    out_steps_d  = out_steps_q;
    rd_cnt_d     = rd_cnt_q;
    pass_d       = pass_q;
    idx_d        = idx_q;
    col_d        = col_q;
    rows_d       = rows_q;
    prev_d       = prev_q;
    phase_d      = phase_q;
    has_prev_d   = has_prev_q;
    has_next_d   = has_next_q;
    has_after_d  = has_after_q;
    base_d       = base_q;
    rd_addr_d    = rd_addr_q;
    p0_d         = p0_q;
    p1_d         = p1_q;
    p2_d         = p2_q;
    p3_d         = p3_q;
    t1_d         = t1_q;
    c2_d         = c2_q;
    c3_d         = c3_q;
    prod_d       = prod_q;
    part_d       = part_q;
    sum_d        = sum_q;
    x_d          = x_q;
    res_value_d  = res_value_q;
    res_sat_d    = res_sat_q;
    res_status_d = res_status_q;
    value_d      = value_q;
    sat_d        = sat_q;
    status_d     = status_q;

    // Drop the output word once taken
    out_valid_d = out_valid_q && out_stall_i;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NUM_COLS:  num_cols_d  = cfg_data_i[NUM_COLS_W-1:0];
        CFG_OUT_STEPS: out_steps_d = cfg_data_i[OUT_STEPS_W-1:0];
        default: begin
          num_cols_d = num_cols_q;
        end
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (action_i)
            ACT_CLEAR: loaded_d = '0;
            ACT_LOAD: begin
              if (load_ok) begin
                loaded_d = loaded_q + 1'b1;
              end
            end
            ACT_QUERY: begin
              idx_d   = out_index_i;
              col_d   = column_i;
              state_d = S_ROWS;
            end
            default: begin
              loaded_d = loaded_q;
            end
          endcase
        end
      end
      S_ROWS: begin
        if (div_stat.done) begin
          rows_d  = (div_quo > DVD_W'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(div_quo);
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        res_value_d  = '0;
        res_sat_d    = 1'b0;
        res_status_d = ST_OK;
        prod_d       = mul_p;
        if (rows_q < RW'(2)) begin
          res_status_d = ST_FEW_ROWS;
          state_d      = S_DONE;
        end else if (({1'b0, idx_q} >= steps) || ({1'b0, col_q} >= ncols)) begin
          res_status_d = ST_OUT_RANGE;
          state_d      = S_DONE;
        end else if (col_q == '0) begin
          // time column answers with the output row itself
          res_value_d = SAMPLE_W'(idx_q);
          state_d     = S_DONE;
        end else begin
          state_d = S_POS;
        end
      end
      S_POS: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          prev_d      = q_prev;
          has_prev_d  = q_prev != '0;
          has_next_d  = q_has_next;
          has_after_d = q_has_next && (({1'b0, q_prev} + 1'b1) < {1'b0, rows_m1});
          // last row: next clamps onto prev, so hold phase at zero
          phase_d     = q_has_next ? div_quo[PHASE_W-1:0] : '0;
          state_d     = S_ADDR;
        end
      end
      S_ADDR: begin
        prod_d  = mul_p;
        state_d = S_BASE;
      end
      S_BASE: begin
        base_d    = prod_q[ADDR_W-1:0] + ADDR_W'(col_q);
        rd_addr_d = prod_q[ADDR_W-1:0] + ADDR_W'(col_q);
        rd_cnt_d  = '0;
        state_d   = S_READ;
      end
      S_READ: begin
        // issue p1, p2, p3, p0 in turn; each read's data arrives in the next cycle
        rd_cnt_d = rd_cnt_q + 1'b1;
        case (rd_cnt_q)
          3'd0: rd_addr_d = rd_addr_q + (has_next_q ? ncols_a : '0);
          3'd1: begin
            p1_d      = $signed(ram_rdata);
            rd_addr_d = rd_addr_q + (has_after_q ? ncols_a : '0);
          end
          3'd2: begin
            p2_d      = $signed(ram_rdata);
            rd_addr_d = base_q - (has_prev_q ? ncols_a : '0);
          end
          3'd3: p3_d = $signed(ram_rdata);
          default: begin
            p0_d    = $signed(ram_rdata);
            state_d = S_COEF;
          end
        endcase
      end
      S_COEF: begin
        t1_d    = t1_w;
        c3_d    = ((C_W'(p1_q) - C_W'(p2_q)) <<< 2) + C_W'(t1_w) + C_W'(t2_w);
        c2_d    = (d21_w <<< 2) + (d21_w <<< 1) - (C_W'(t1_w) <<< 1) - C_W'(t2_w);
        pass_d  = 1'b0;
        state_d = S_MC3;
      end
      S_MC3: begin
        prod_d  = mul_p;
        state_d = S_ASUM;
      end
      S_ASUM: begin
        x_d     = (X_W'(c2_q) <<< PHASE_W) + X_W'(prod_q);
        state_d = S_MLO;
      end
      S_MLO: begin
        prod_d  = mul_p;
        state_d = S_MHI;
      end
      S_MHI: begin
        // fold the rounding half into the low partial product
        part_d  = ACC_W'(prod_q) + RND16;
        prod_d  = mul_p;
        state_d = S_SUM;
      end
      S_SUM: begin
        sum_d   = (ACC_W'(prod_q) <<< X_LO_W) + part_q;
        state_d = S_UPD;
      end
      S_UPD: begin
        if (!pass_q) begin
          x_d     = (X_W'(t1_q) <<< PHASE_W) + X_W'(tail);
          pass_d  = 1'b1;
          state_d = S_MLO;
        end else begin
          x_d     = (X_W'(p1_q) <<< (PHASE_W + 1)) + X_W'(tail);
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        res_status_d = ST_OK;
        if (fin_r > R_MAX) begin
          res_value_d = V_MAX;
          res_sat_d   = 1'b1;
        end else if (fin_r < R_MIN) begin
          res_value_d = V_MIN;
          res_sat_d   = 1'b1;
        end else begin
          res_value_d = SAMPLE_W'(fin_r);
          res_sat_d   = 1'b0;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        // advance once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          value_d     = res_value_q;
          sat_d       = res_sat_q;
          status_d    = res_status_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      loaded_q    <= '0;
      num_cols_q  <= NUM_COLS_RST;
      out_steps_q <= OUT_STEPS_RST;
      rd_cnt_q    <= '0;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      num_cols_q  <= num_cols_d;
      out_steps_q <= out_steps_d;
      rd_cnt_q    <= rd_cnt_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    col_q        <= col_d;
    rows_q       <= rows_d;
    prev_q       <= prev_d;
    phase_q      <= phase_d;
    has_prev_q   <= has_prev_d;
    has_next_q   <= has_next_d;
    has_after_q  <= has_after_d;
    base_q       <= base_d;
    rd_addr_q    <= rd_addr_d;
    p0_q         <= p0_d;
    p1_q         <= p1_d;
    p2_q         <= p2_d;
    p3_q         <= p3_d;
    t1_q         <= t1_d;
    c2_q         <= c2_d;
    c3_q         <= c3_d;
    prod_q       <= prod_d;
    part_q       <= part_d;
    sum_q        <= sum_d;
    x_q          <= x_d;
    res_value_q  <= res_value_d;
    res_sat_q    <= res_sat_d;
    res_status_q <= res_status_d;
    value_q      <= value_d;
    sat_q        <= sat_d;
    status_q     <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign saturated_o = sat_q;
  assign status_o    = status_q;

  `ASSERT_NEXT(a_load_count, clk_i, rst_ni, load_ok, loaded_q == LD_W'($past(loaded_q) + 1'b1), "load did not advance the fill count")
  `ASSERT_IMPL(a_load_bound, clk_i, rst_ni, 1'b1, loaded_q <= LD_W'(DEPTH), "fill count beyond store depth")
  `ASSERT_IMPL(a_div_free, clk_i, rst_ni, div_start, !div_stat.busy, "divider restarted while busy")
  `ASSERT_IMPL(a_fail_clean, clk_i, rst_ni, out_valid_q && (status_q != ST_OK), (value_q == '0) && !sat_q, "failed query carries data")
  `ASSERT_IMPL(a_sat_ok, clk_i, rst_ni, out_valid_q && sat_q, status_q == ST_OK, "saturation flag on a failed query")

endmodule

FILE: tb/catmull_rom_trajectory_resampler_test.sv
`timescale 1ns / 100ps

module catmull_rom_trajectory_resampler_test;
  import crtr_pkg::*;

  localparam int unsigned MAX_ROWS      = 1024;
  localparam int unsigned MAX_COLS      = 16;
  localparam int unsigned MAX_OUT_STEPS = 4096;
  localparam int unsigned STORE_DEPTH   = MAX_ROWS * MAX_COLS;

  // Register indexes past the defined pair; the block must ignore them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int SETTLE_CYCLES     = 8;
  localparam int END_CYCLES        = 150;
  localparam int LONG_HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT       = 1000000;

  typedef struct packed {
    logic [ACTION_W-1:0]        action;
    logic signed [SAMPLE_W-1:0] sample;
    logic [INDEX_W-1:0]         out_index;
    logic [COLUMN_W-1:0]        column;
  } word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       saturated;
    logic [STATUS_W-1:0]        status;
  } element_t;

  // Clock, reset and every block input start at known values.
  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  logic [ACTION_W-1:0]         action_i    = ACT_NOP;
  logic signed [SAMPLE_W-1:0]  sample_i    = '0;
  logic [INDEX_W-1:0]          out_index_i = '0;
  logic [COLUMN_W-1:0]         column_i    = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0]  value_o;
  logic                        saturated_o;
  logic [STATUS_W-1:0]         status_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [CFG_IDX_W-1:0]        cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]       cfg_data_i  = '0;

  // Shadow copy of the block state: store on accepted words, registers on writes.
  logic signed [SAMPLE_W-1:0]  traj_mem [STORE_DEPTH];
  int unsigned                 samples_held = 0;
  logic [NUM_COLS_W-1:0]       cfg_cols     = NUM_COLS_RST;
  logic [OUT_STEPS_W-1:0]      cfg_steps    = OUT_STEPS_RST;

  word_t    stim_words[$];
  element_t predicted_elements[$];
  word_t    cur_word;
  int       words_queued    = 0;
  int       words_accepted  = 0;
  int       error_count     = 0;
  int       cycle_count     = 0;
  int       send_gap        = 0;
  int       stall_left      = 0;
  bit       idle_on         = 1'b1;
  bit       long_hold_arm   = 1'b0;
  bit       long_hold_done  = 1'b0;

  catmull_rom_trajectory_resampler #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_COLS      (MAX_COLS),
    .MAX_OUT_STEPS (MAX_OUT_STEPS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .sample_i    (sample_i),
    .out_index_i (out_index_i),
    .column_i    (column_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .saturated_o (saturated_o),
    .status_o    (status_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow model of the resampler
  // ---------------------------------------------------------------------------

  // Clamp the register values the same way the block does.
  function automatic int unsigned eff_cols();
    if (cfg_cols == 0) return 1;
    if (cfg_cols > MAX_COLS) return MAX_COLS;
    return cfg_cols;
  endfunction

  function automatic int unsigned eff_steps();
    if (cfg_steps < 2) return 2;
    if (cfg_steps > MAX_OUT_STEPS) return MAX_OUT_STEPS;
    return cfg_steps;
  endfunction

  function automatic longint row_sample(int unsigned row, int unsigned col,
                                        int unsigned ncols);
    return longint'(traj_mem[row * ncols + col]);
  endfunction

  // Round half toward plus infinity; >>> on a signed longint floors.
  function automatic longint round_q(longint x, int k);
    return (x + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  // Work out one element of the resampled trajectory.
  function automatic element_t resample_element(logic [INDEX_W-1:0] idx,
                                                logic [COLUMN_W-1:0] col);
    int unsigned       ncols, steps, rows, d, prev, nxt, pm, pn;
    longint unsigned   pos;
    longint            phase, p0, p1, p2, p3, t1, t2, c2, c3, a, b, v, r;
    element_t          e;
    ncols = eff_cols();
    steps = eff_steps();
    rows  = samples_held / ncols;
    if (rows > MAX_ROWS) rows = MAX_ROWS;
    e = '0;
    // Too few rows wins over the range check.
    if (rows < 2) begin
      e.status = ST_FEW_ROWS;
      return e;
    end
    if (idx >= steps || col >= ncols) begin
      e.status = ST_OUT_RANGE;
      return e;
    end
    e.status = ST_OK;
    // Time column: hand back the output row index.
    if (col == 0) begin
      e.value = idx;
      return e;
    end
    // Map the output row to a source row and a Q0.16 phase.
    d     = steps - 1;
    pos   = longint'(idx) * (rows - 1);
    prev  = pos / d;
    if (prev > rows - 1) prev = rows - 1;
    phase = ((pos % d) << 16) / d;
    // Clamp the next row on the last output row; the phase drops to zero.
    nxt = prev + 1;
    if (nxt > rows - 1) begin
      nxt   = rows - 1;
      phase = 0;
    end
    pm = (prev > 0) ? prev - 1 : prev;
    pn = (nxt < rows - 1) ? nxt + 1 : nxt;
    p0 = row_sample(pm, col, ncols);
    p1 = row_sample(prev, col, ncols);
    p2 = row_sample(nxt, col, ncols);
    p3 = row_sample(pn, col, ncols);
    // Twice the tangents and the cubic coefficients, Horner form in Q16.
    t1 = p2 - p0;
    t2 = p3 - p1;
    c3 = 4 * (p1 - p2) + t1 + t2;
    c2 = 6 * (p2 - p1) - 2 * t1 - t2;
    a  = c2 * 65536 + phase * c3;
    b  = t1 * 65536 + round_q(phase * a, 16);
    v  = 2 * p1 * 65536 + round_q(phase * b, 16);
    r  = round_q(v, 17);
    if (r > 32767) begin
      r = 32767;
      e.saturated = 1'b1;
    end else if (r < -32768) begin
      r = -32768;
      e.saturated = 1'b1;
    end
    e.value = r[SAMPLE_W-1:0];
    return e;
  endfunction

  // Advance the shadow state by one accepted input word.
  task automatic apply_word(input word_t w);
    case (w.action)
      ACT_CLEAR: samples_held = 0;
      ACT_LOAD: begin
        // Drop loads once the store is full.
        if (samples_held < STORE_DEPTH) begin
          traj_mem[samples_held] = w.sample;
          samples_held++;
        end
      end
      ACT_QUERY: begin
        predicted_elements = {predicted_elements,
                              resample_element(w.out_index, w.column)};
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: pop the next word whenever the current one is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        apply_word(cur_word);
        words_accepted++;
      end
      // Hold the payload while stalled; otherwise advance or idle.
      if (!in_valid_i || !in_stall_o) begin
        if (idle_on && send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (stim_words.size() != 0) begin
          cur_word    = stim_words.pop_front();
          action_i    <= cur_word.action;
          sample_i    <= cur_word.sample;
          out_index_i <= cur_word.out_index;
          column_i    <= cur_word.column;
          in_valid_i  <= 1'b1;
          // Schedule a burst of idle cycles after this word now and then.
          if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 4);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare against the oldest prediction, drive stall
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    element_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_elements.size() == 0) begin
          report_mismatch($sformatf("result word with nothing expected (value %0d status %0d)",
                                    value_o, status_o));
        end else begin
          want = predicted_elements.pop_front();
          if (status_o !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
          if (value_o !== want.value)
            report_mismatch($sformatf("value got %0d want %0d", value_o, want.value));
          if (saturated_o !== want.saturated)
            report_mismatch($sformatf("saturated got %0d want %0d (value %0d)",
                                      saturated_o, want.saturated, want.value));
        end
      end
      // Long hold first, then random stall bursts while idling is on.
      if (long_hold_arm && !long_hold_done) begin
        out_stall_i <= 1'b1;
      end else if (!idle_on) begin
        out_stall_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Count out the long receiver hold in a process of its own.
  initial begin
    wait (long_hold_arm);
    repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
    long_hold_done <= 1'b1;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // num_cols data word with random upper bits the block must mask off.
  function automatic logic [CFG_DATA_W-1:0] cols_word(int c);
    return {8'($urandom), 5'(c)};
  endfunction

  task automatic queue_word(input logic [ACTION_W-1:0] act,
                            input logic signed [SAMPLE_W-1:0] smp,
                            input logic [INDEX_W-1:0] idx,
                            input logic [COLUMN_W-1:0] col);
    word_t w;
    w.action    = act;
    w.sample    = smp;
    w.out_index = idx;
    w.column    = col;
    stim_words = {stim_words, w};
    words_queued++;
  endtask

  task automatic queue_load(input logic signed [SAMPLE_W-1:0] smp);
    queue_word(ACT_LOAD, smp, INDEX_W'($urandom), COLUMN_W'($urandom));
  endtask

  task automatic queue_query(input int idx, input int col);
    queue_word(ACT_QUERY, SAMPLE_W'($urandom), INDEX_W'(idx), COLUMN_W'(col));
  endtask

  task automatic load_rows(input int nrows, input int ncols, input int extra);
    for (int i = 0; i < nrows * ncols + extra; i++) queue_load(rand_sample());
  endtask

  // Wait until every word is taken and every result checked, then settle.
  task automatic wait_idle(input int settle);
    do @(negedge clk_i);
    while (words_accepted != words_queued || predicted_elements.size() != 0);
    repeat (settle) @(negedge clk_i);
  endtask

  // Write one register; the block is idle whenever this is called.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_NUM_COLS) cfg_cols = data[NUM_COLS_W-1:0];
    else if (idx == CFG_OUT_STEPS) cfg_steps = data[OUT_STEPS_W-1:0];
  endtask

  // One phase: set both registers, optionally refill, then a query mix.
  // fill: 0 keep the store, 1 clear and load a few rows.
  task automatic run_phase(input logic [CFG_DATA_W-1:0] cols_data,
                           input logic [CFG_DATA_W-1:0] steps_data,
                           input int n_queries, input bit hold, input int fill);
    int ncols, steps, nrows, pick, idx, col;
    write_reg(CFG_NUM_COLS, cols_data);
    write_reg(CFG_OUT_STEPS, steps_data);
    ncols = eff_cols();
    steps = eff_steps();
    // Long trajectories only when rows are narrow; wide rows stay short.
    if (ncols <= 2 && $urandom_range(0, 2) == 0) nrows = $urandom_range(13, 40);
    else nrows = $urandom_range(2, (ncols > 4) ? 4 : 10);
    @(negedge clk_i);
    if (fill != 0) queue_word(ACT_CLEAR, rand_sample(), INDEX_W'($urandom), COLUMN_W'($urandom));
    if (fill == 1) load_rows(nrows, ncols, $urandom_range(0, ncols - 1));
    if (hold) long_hold_arm = 1'b1;
    for (int q = 0; q < n_queries; q++) begin
      // Pause the sender once per phase until the block has drained.
      if (q == n_queries / 2) wait_idle(0);
      pick = $urandom_range(0, 19);
      idx  = $urandom_range(0, steps - 1);
      col  = (ncols > 1) ? $urandom_range(1, ncols - 1) : 0;
      case (pick)
        0: queue_word(ACT_NOP, rand_sample(), INDEX_W'($urandom), COLUMN_W'($urandom));
        1: if (steps < MAX_OUT_STEPS) idx = $urandom_range(steps, 4095);
        2: col = $urandom_range(0, 15);
        3: queue_load(rand_sample());
        4: idx = steps - 1;
        5: col = 0;
        6: begin
          // Occasionally rebuild the trajectory mid-phase.
          if (fill == 1 && $urandom_range(0, 3) == 0) begin
            queue_word(ACT_CLEAR, rand_sample(), INDEX_W'($urandom), COLUMN_W'($urandom));
            load_rows(nrows, ncols, 0);
          end
        end
        default: ;
      endcase
      if (pick != 0 && pick != 3) queue_query(idx, col);
    end
    wait_idle(SETTLE_CYCLES);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty store at reset config: queries must report too few rows,
    // even when the index is also out of range.
    queue_query(0, 0);
    queue_word(ACT_NOP, 16'sh7fff, 12'hfff, 4'hf);
    queue_load(-16'sd1);
    queue_query(4095, 15);
    wait_idle(SETTLE_CYCLES);

    // Four rows, three columns; column 1 overshoots high between the middle
    // rows, column 2 overshoots low, so both saturate at the half phase.
    write_reg(CFG_NUM_COLS, 13'd3);
    write_reg(CFG_OUT_STEPS, 13'd3);
    @(negedge clk_i);
    queue_word(ACT_CLEAR, 16'sh0, 12'h0, 4'h0);
    queue_load(16'sd0); queue_load(16'sh8000); queue_load(16'sh7fff);
    queue_load(16'sd1); queue_load(16'sh7fff); queue_load(16'sh8000);
    queue_load(16'sd2); queue_load(16'sh7fff); queue_load(16'sh8000);
    queue_load(16'sd3); queue_load(16'sh8000); queue_load(16'sh7fff);
    queue_query(0, 1);
    queue_query(1, 1);
    queue_query(1, 2);
    queue_query(2, 1);    // last output row, next row clamped
    queue_query(1, 0);    // time column
    queue_query(3, 1);    // index past out_steps
    queue_query(1, 3);    // column past num_cols
    queue_word(ACT_CLEAR, 16'sh7fff, 12'hfff, 4'hf);
    queue_query(0, 1);
    wait_idle(SETTLE_CYCLES);

    // Register extremes and random settings with random trajectories.
    run_phase(cols_word(0), 13'd0, 30, 1'b0, 1);
    run_phase(cols_word(31), 13'd8191, 30, 1'b0, 1);
    run_phase(cols_word(16), 13'd4096, 40, 1'b1, 1);
    run_phase(cols_word(1), 13'd2, 30, 1'b0, 1);
    write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
    run_phase(cols_word(17), 13'd4097, 30, 1'b0, 1);
    for (int i = 0; i < 2; i++)
      run_phase(cols_word($urandom_range(0, 31)),
                ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                            : CFG_DATA_W'($urandom_range(2, 64)),
                40, 1'b0, 1);

    // Reread the stored trajectory with other column counts, no reload.
    run_phase(cols_word(1), 13'd4096, 20, 1'b0, 0);
    run_phase(cols_word(7), 13'd100, 20, 1'b0, 0);

    // Finish at full rate on both sides.
    idle_on = 1'b0;
    run_phase(cols_word(2), 13'd9, 40, 1'b0, 1);

    repeat (END_CYCLES) @(posedge clk_i);
    if (predicted_elements.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", predicted_elements.size()));
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/crtr_pkg.sv
src/crtr_ram.sv
src/crtr_div.sv
src/catmull_rom_trajectory_resampler.sv
tb/catmull_rom_trajectory_resampler_test.sv
